/* sv/ryuv_pkg.sv */
// ----------------------------------------------------------------------------
// ryuv_pkg - shared types and constants for the RGB565 to YUV420 converter
// Chroma kind codes, config register indexes, BT.601 integer coefficients
// and the round/offset/clip helper.
// ----------------------------------------------------------------------------
package ryuv_pkg;

  // Config port geometry
  localparam int CfgDataW = 13;
  localparam int CfgIdxW  = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [CfgDataW-1:0] FrameWidthRst  = 13'd720;
  localparam logic [CfgDataW-1:0] FrameHeightRst = 13'd480;

  // Chroma kind carried on tuser
  typedef enum logic [1:0] {
    CK_NONE = 2'd0,
    CK_U    = 2'd1,
    CK_V    = 2'd2
  } chroma_kind_e;

  // Position info for one item
  typedef struct packed {
    chroma_kind_e kind;
    logic         frame_end;
  } pos_t;

  // Field widths
  localparam int PixW  = 16;
  localparam int SmpW  = 8;
  localparam int SumW  = 18;   // holds any weighted sum of 8-bit R/G/B
  localparam int ClipW = 11;   // scaled sum plus offset

  // BT.601 integer coefficients
  localparam logic signed [SumW-1:0] YR = 18'sd66;
  localparam logic signed [SumW-1:0] YG = 18'sd129;
  localparam logic signed [SumW-1:0] YB = 18'sd25;
  localparam logic signed [SumW-1:0] UR = -18'sd38;
  localparam logic signed [SumW-1:0] UG = -18'sd74;
  localparam logic signed [SumW-1:0] UB = 18'sd112;
  localparam logic signed [SumW-1:0] VR = 18'sd112;
  localparam logic signed [SumW-1:0] VG = -18'sd94;
  localparam logic signed [SumW-1:0] VB = -18'sd18;
  localparam logic signed [SumW-1:0] RoundBias = 18'sd128;

  localparam logic signed [ClipW-1:0] LumaOffset   = 11'sd16;
  localparam logic signed [ClipW-1:0] ChromaOffset = 11'sd128;

  // (sum + 128) >>> 8, plus offset, clipped to 0..255
  function automatic logic [SmpW-1:0] scale_clip(input logic signed [SumW-1:0] sum,
                                                 input logic signed [ClipW-1:0] offset);
    logic signed [SumW-1:0]  biased;
    logic signed [ClipW-1:0] v;
    biased = sum + RoundBias;
    // bits 17..8 are the arithmetic shift by 8, sign-extended by one
    v = signed'({biased[SumW-1], biased[SumW-1:8]}) + offset;
    if (v < 0) begin
      scale_clip = '0;
    end else if (v > 11'sd255) begin
      scale_clip = '1;
    end else begin
      scale_clip = v[SmpW-1:0];
    end
  endfunction

endpackage

/* sv/ryuv_pos.sv */
// ----------------------------------------------------------------------------
// ryuv_pos - raster position tracker
// Column/row counters wrapped by the clamped frame size; gives chroma kind
// and end-of-frame for the current item and advances on each accepted item.
// ----------------------------------------------------------------------------
module ryuv_pos
  import ryuv_pkg::*;
#(
  parameter int MaxDimension = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [CfgDataW-1:0] frame_width_i,
  input  logic [CfgDataW-1:0] frame_height_i,
  output pos_t                pos_o
);

  localparam int CntW = $clog2(MaxDimension);
  localparam int DimW = $clog2(MaxDimension + 1);
  localparam int SzW  = (DimW > CfgDataW) ? DimW : CfgDataW;

  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;
  logic [DimW-1:0] width_c, height_c;
  logic            row_last, frame_last;

  // clamp a size register into 2..MaxDimension
  function automatic logic [DimW-1:0] clamp_size(input logic [CfgDataW-1:0] v);
    logic [SzW-1:0] ext;
    ext = SzW'(v);
    if (ext < SzW'(2)) begin
      clamp_size = DimW'(2);
    end else if (ext > SzW'(MaxDimension)) begin
      clamp_size = DimW'(MaxDimension);
    end else begin
      clamp_size = ext[DimW-1:0];
    end
  endfunction

  assign width_c  = clamp_size(frame_width_i);
  assign height_c = clamp_size(frame_height_i);

  // end of row / frame; a counter beyond a shrunk size also ends it
  assign row_last   = DimW'(col_q) >= (width_c - DimW'(1));
  assign frame_last = row_last && (DimW'(row_q) >= (height_c - DimW'(1)));

  // chroma kind from parity
  always_comb begin
    pos_o.frame_end = frame_last;
    if (col_q[0]) begin
      pos_o.kind = CK_NONE;
    end else if (!row_q[0]) begin
      pos_o.kind = CK_U;
    end else begin
      pos_o.kind = CK_V;
    end
  end

  // counter next values
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (row_last) begin
        col_d = '0;
        row_d = frame_last ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* sv/ryuv_csc.sv */
// ----------------------------------------------------------------------------
// ryuv_csc - RGB565 to YUV color conversion
// Expands the pixel to 8-bit R/G/B and forms luma and the selected chroma
// sample with BT.601 integer coefficients, rounding and clipping.
// ----------------------------------------------------------------------------
module ryuv_csc
  import ryuv_pkg::*;
(
  input  logic [PixW-1:0] pixel_i,
  input  chroma_kind_e    kind_i,
  output logic [SmpW-1:0] luma_o,
  output logic [SmpW-1:0] chroma_o
);

  logic signed [SumW-1:0] r_s, g_s, b_s;
  logic signed [SumW-1:0] y_sum, u_sum, v_sum;

  // expand to 8 bits, low bits zero
  assign r_s = signed'(SumW'({pixel_i[15:11], 3'b000}));
  assign g_s = signed'(SumW'({pixel_i[10:5], 2'b00}));
  assign b_s = signed'(SumW'({pixel_i[4:0], 3'b000}));

  // constant-coefficient weighted sums
  assign y_sum = YR * r_s + YG * g_s + YB * b_s;
  assign u_sum = UR * r_s + UG * g_s + UB * b_s;
  assign v_sum = VR * r_s + VG * g_s + VB * b_s;

  assign luma_o = scale_clip(y_sum, LumaOffset);

  always_comb begin
    case (kind_i)
      CK_U:    chroma_o = scale_clip(u_sum, ChromaOffset);
      CK_V:    chroma_o = scale_clip(v_sum, ChromaOffset);
      default: chroma_o = '0;
    endcase
  end

endmodule

/* sv/rgb565_to_yuv420_pixel_stream_top.sv */
// ----------------------------------------------------------------------------
// rgb565_to_yuv420_pixel_stream_top - RGB565 to YUV420 pixel stream
// Converts raster-order RGB565 pixels to Y plus subsampled U/V samples.
// ----------------------------------------------------------------------------
// Takes one RGB565 pixel per item and returns one item per pixel: the luma
// sample, and on even columns a U (even rows) or V (odd rows) sample with its
// kind on tuser; tlast marks the last pixel of a frame. Frame width and height
// come from config registers 0 and 1, clamped to 2..MAX_DIMENSION; write them
// only while the stream is idle. Throughput is one item per clock. The pipeline
// is an input register holding the pixel and its position, then the conversion
// logic feeding the result register. Both stages stall in place when the output
// is held off.
module rgb565_to_yuv420_pixel_stream_top
  import ryuv_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // pixel input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] pixel
  // YUV output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [7:0] luma, [15:8] chroma
  output logic [1:0]          m_axis_tuser,   // [1:0] chroma_kind
  output logic                m_axis_tlast    // frame_end
);

  logic [CfgDataW-1:0] frame_width_q, frame_height_q;

  logic            in_accept, s1_ready, out_ready;
  logic            s1_valid_q, s1_valid_d;
  logic [PixW-1:0] s1_pixel_q;
  pos_t            s1_pos_q;
  pos_t            pos_c;

  logic            out_valid_q, out_valid_d;
  logic [SmpW-1:0] out_luma_q, out_chroma_q;
  logic [SmpW-1:0] luma_c, chroma_c;
  pos_t            out_pos_q;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;
  assign in_accept     = s_axis_tvalid && s1_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (out_ready) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_ready ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // raster position
  ryuv_pos #(
    .MaxDimension(MAX_DIMENSION)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (in_accept),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .pos_o         (pos_c)
  );

  // input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pixel_q <= s_axis_tdata;
      s1_pos_q   <= pos_c;
    end
  end

  // color conversion
  ryuv_csc u_csc (
    .pixel_i (s1_pixel_q),
    .kind_i  (s1_pos_q.kind),
    .luma_o  (luma_c),
    .chroma_o(chroma_c)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_luma_q   <= luma_c;
      out_chroma_q <= chroma_c;
      out_pos_q    <= s1_pos_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_chroma_q, out_luma_q};
  assign m_axis_tuser  = out_pos_q.kind;
  assign m_axis_tlast  = out_pos_q.frame_end;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for the RGB565 to YUV420 pixel stream converter
// Streams RGB565 pixels through the block under several frame sizes, mid-frame
// size changes and random back-pressure, and checks every output item against
// a behavioral model of the luma/chroma math and the raster counters.
// ----------------------------------------------------------------------------
module tb;
  import ryuv_pkg::*;

  localparam int RandomItems = 2000;

  // one expected output item
  typedef struct {
    logic [7:0]   luma;
    chroma_kind_e kind;
    logic [7:0]   chroma;
    logic         frame_end;
  } yuv_sample_t;

  // Behavioral model of the converter plus the queue of pending samples
  class yuv420_tracker;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    int          col;
    int          row;
    int          errors;
    yuv_sample_t expected_samples[$];

    function new();
      width_reg  = 13'd720;
      height_reg = 13'd480;
      col        = 0;
      row        = 0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [12:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    // sizes outside 2..4096 saturate
    static function int clamp_dim(logic [12:0] v);
      if (v < 13'd2) return 2;
      if (v > 13'd4096) return 4096;
      return int'(v);
    endfunction

    // (sum + 128) >>> 8, plus offset, clipped to a byte
    static function logic [7:0] round_clip(int sum, int offset);
      int v;
      v = ((sum + 128) >>> 8) + offset;
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function void note_pixel(logic [15:0] px);
      yuv_sample_t s;
      int          r, g, b, w, h;
      bit          row_last, frame_last;
      r = int'({px[15:11], 3'b000});
      g = int'({px[10:5], 2'b00});
      b = int'({px[4:0], 3'b000});
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      row_last   = col >= w - 1;
      frame_last = row_last && (row >= h - 1);
      s.luma = round_clip(66 * r + 129 * g + 25 * b, 16);
      if (col[0] == 1'b0 && row[0] == 1'b0) begin
        s.kind   = CK_U;
        s.chroma = round_clip(-38 * r - 74 * g + 112 * b, 128);
      end else if (col[0] == 1'b0) begin
        s.kind   = CK_V;
        s.chroma = round_clip(112 * r - 94 * g - 18 * b, 128);
      end else begin
        s.kind   = CK_NONE;
        s.chroma = 8'd0;
      end
      s.frame_end = frame_last;
      expected_samples.push_back(s);
      // raster position of the next pixel
      if (row_last) begin
        col = 0;
        row = frame_last ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void check_result(logic [7:0] luma, logic [1:0] kind, logic [7:0] chroma,
                               logic frame_end);
      yuv_sample_t s;
      if (expected_samples.size() == 0) begin
        $error("output item with none expected: luma %0d kind %0d", luma, kind);
        errors++;
        return;
      end
      s = expected_samples.pop_front();
      if (luma !== s.luma) begin
        $error("luma mismatch: expected %0d, actual %0d", s.luma, luma);
        errors++;
      end
      if (kind !== s.kind) begin
        $error("chroma_kind mismatch: expected %0d, actual %0d", s.kind, kind);
        errors++;
      end
      if (chroma !== s.chroma) begin
        $error("chroma mismatch: expected %0d, actual %0d", s.chroma, chroma);
        errors++;
      end
      if (frame_end !== s.frame_end) begin
        $error("frame_end mismatch: expected %0d, actual %0d", s.frame_end, frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  cfg_reg_e            cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;   // [15:0] pixel
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // [7:0] luma, [15:8] chroma
  logic [1:0]          m_axis_tuser;   // [1:0] chroma_kind
  logic                m_axis_tlast;   // frame_end

  yuv420_tracker sb;
  bit            tx_burst;
  bit            rx_burst;
  int            pixels_sent;

  rgb565_to_yuv420_pixel_stream_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  // Monitor: note accepted pixels, then check accepted output items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8], m_axis_tlast);
    end
  end

  // Output side: random hold-off before each item, none in burst stretches
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = rx_burst ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_pixel(input logic [15:0] px);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pixels_sent++;
  endtask

  // Stop the input and wait until every pending sample has come out
  task automatic drain_stream();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [12:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly small frames, sometimes any 13-bit value or an edge value
  function automatic logic [12:0] pick_dim(int small_max);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 13'($urandom_range(2, small_max));
    if (sel == 7) return 13'($urandom_range(0, 8191));
    case ($urandom_range(0, 5))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd2;
      3:       return 13'd4096;
      4:       return 13'd4097;
      default: return 13'd8191;
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [15:0] corner_px [10];
    int          mode, n;
    corner_px = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F,
                  16'h8410, 16'h7BEF, 16'hF81F, 16'h07FF, 16'h0821};
    sb            = new();
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    pixels_sent   = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_FRAME_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset sizes, first row only: color extremes and primaries
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    drain_stream();

    // Shrink mid-row: column already past the new row end, then U/V/none rows
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    for (int i = 0; i < 8; i++) send_pixel(corner_px[i]);
    drain_stream();

    // Sizes below the minimum act as 2x2
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    for (int i = 0; i < 4; i++) send_pixel(corner_px[9 - i]);
    drain_stream();

    // Sizes above the maximum saturate, then shrink the row again
    write_reg(REG_FRAME_WIDTH, 13'd8191);
    write_reg(REG_FRAME_HEIGHT, 13'd8191);
    for (int i = 0; i < 3; i++) send_pixel(corner_px[i + 1]);
    drain_stream();
    write_reg(REG_FRAME_WIDTH, 13'd2);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    drain_stream();

    // Random phases: new sizes at idle points, random pixels and pacing
    while (pixels_sent < RandomItems + 27) begin
      mode = $urandom_range(0, 3);
      if (mode != 2) write_reg(REG_FRAME_WIDTH, pick_dim(9));
      if (mode != 1) write_reg(REG_FRAME_HEIGHT, pick_dim(6));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 150);
      for (int i = 0; i < n; i++) send_pixel(16'($urandom_range(0, 65535)));
      drain_stream();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
